// ----- rtl/wsd_pkg.sv -----
// Package for the WebSocket frame deframer: parse phases, result codes,
// header constants and the result struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  // Parse phases, one-hot
  typedef enum logic [5:0] {
    PH_HDR0   = 6'b000001,
    PH_HDR1   = 6'b000010,
    PH_EXTLEN = 6'b000100,
    PH_MASK   = 6'b001000,
    PH_BODY   = 6'b010000,
    PH_HALT   = 6'b100000
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // End reasons
  localparam logic [1:0] RSN_CLOSE    = 2'd0;
  localparam logic [1:0] RSN_FRAG     = 2'd1;
  localparam logic [1:0] RSN_OVERSIZE = 2'd2;

  // Opcodes with special handling
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // Second header byte length codes
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Header byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // Configuration space
  localparam int unsigned APB_ADDR_W      = 3;
  localparam int unsigned MAX_PAYLOAD_W   = 21;
  localparam logic [0:0]  REG_MAX_PAYLOAD = 1'b0;
  localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RST = 21'd4096;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       last_byte;
    logic [1:0] end_reason;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/wsd_cfg_regs.sv -----
// APB register file for the deframer: holds max_payload.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_cfg_regs
  import wsd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_W-1:0]    paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready,
  output logic      [MAX_PAYLOAD_W-1:0] max_payload
);

  logic [APB_ADDR_W-3:0] reg_index;
  logic                  wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_W-1:2];
  assign wr_en     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RST;
    end else if (wr_en && reg_index == REG_MAX_PAYLOAD) begin
      max_payload <= pwdata[MAX_PAYLOAD_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_MAX_PAYLOAD: prdata = 32'(max_payload);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/wsd_parser.sv -----
// Header parser and unmasker: input register, parse state and the per-byte
// next-state / result logic. Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_parser
  import wsd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = 1048576
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [7:0]               in_byte,
  input  wire logic [MAX_PAYLOAD_W-1:0] max_payload,
  input  wire logic                     out_ready,
  output logic                          res_valid,
  output result_t                       res
);

  localparam int unsigned LEN_W = $clog2(MAX_FRAME_LEN + 1);
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_FRAME_LEN);

  // input register
  logic       ibuf_valid;
  logic [7:0] ibuf_byte;
  logic       advance;

  // parse state
  phase_t            phase, phase_next;
  logic [3:0]        header_count, header_count_next;
  logic [3:0]        held_opcode, held_opcode_next;
  logic              fin_flag, fin_flag_next;
  logic              mask_flag, mask_flag_next;
  logic [31:0]       mask_key, mask_key_next;
  logic [LEN_W-1:0]  length_acc, length_acc_next;
  logic              length_over, length_over_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [1:0]        mask_index, mask_index_next;
  logic [1:0]        pend_reason, pend_reason_next;
  logic              pend_error, pend_error_next;

  // combinational helpers
  logic [LEN_W+7:0]  len_wide;
  logic              use_new_len;
  logic [LEN_W-1:0]  la_acc;
  logic              la_over;
  logic              mflag;
  logic              over_fixed;
  logic              chk_error;
  logic [1:0]        chk_reason;
  logic [3:0]        hc_dec;
  logic [LEN_W-1:0]  bl_dec;
  logic              after_len;
  logic              start_body;
  logic [7:0]        key_byte;
  logic              emit;

  assign advance  = ibuf_valid & out_ready;
  assign in_ready = ~ibuf_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ibuf_valid <= 1'b0;
    end else if (in_ready) begin
      ibuf_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ibuf_byte <= in_byte;
    end
  end

  // current mask key byte, first key byte applies to payload byte 0
  always_comb begin
    case (mask_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    held_opcode_next  = held_opcode;
    fin_flag_next     = fin_flag;
    mask_flag_next    = mask_flag;
    mask_key_next     = mask_key;
    length_acc_next   = length_acc;
    length_over_next  = length_over;
    bytes_left_next   = bytes_left;
    mask_index_next   = mask_index;
    pend_reason_next  = pend_reason;
    pend_error_next   = pend_error;

    res              = '0;
    res.frame_opcode = held_opcode;
    emit             = 1'b0;
    after_len        = 1'b0;
    start_body       = 1'b0;

    // length as it stands after this byte; anything past LEN_W bits is sticky
    len_wide    = (phase == PH_HDR1) ? (LEN_W + 8)'(ibuf_byte[6:0])
                                     : {length_acc, ibuf_byte};
    use_new_len = (phase == PH_HDR1) || (phase == PH_EXTLEN);
    la_acc      = use_new_len ? len_wide[LEN_W-1:0] : length_acc;
    la_over     = use_new_len ? (((phase == PH_EXTLEN) & length_over)
                                 | (|len_wide[LEN_W+7:LEN_W]))
                              : length_over;
    mflag       = (phase == PH_HDR1) ? ibuf_byte[7] : mask_flag;
    over_fixed  = la_over || (la_acc > MaxLen);
    hc_dec      = header_count - 4'd1;
    bl_dec      = bytes_left - LEN_W'(1);

    // frame checks in priority order: close, unfinished, over max_payload
    if (held_opcode == OP_CLOSE) begin
      chk_error  = 1'b1;
      chk_reason = RSN_CLOSE;
    end else if (!fin_flag) begin
      chk_error  = 1'b1;
      chk_reason = RSN_FRAG;
    end else if (la_over || MAX_PAYLOAD_W'(la_acc) > max_payload) begin
      chk_error  = 1'b1;
      chk_reason = RSN_OVERSIZE;
    end else begin
      chk_error  = 1'b0;
      chk_reason = RSN_CLOSE;
    end

    unique case (phase)
      PH_HDR0: begin
        fin_flag_next    = ibuf_byte[7];
        held_opcode_next = ibuf_byte[3:0];
        phase_next       = PH_HDR1;
      end
      PH_HDR1: begin
        mask_flag_next = ibuf_byte[7];
        if (ibuf_byte[6:0] == LEN_CODE_16) begin
          length_acc_next   = '0;
          length_over_next  = 1'b0;
          header_count_next = EXT16_BYTES;
          phase_next        = PH_EXTLEN;
        end else if (ibuf_byte[6:0] == LEN_CODE_64) begin
          length_acc_next   = '0;
          length_over_next  = 1'b0;
          header_count_next = EXT64_BYTES;
          phase_next        = PH_EXTLEN;
        end else begin
          length_acc_next  = la_acc;
          length_over_next = la_over;
          after_len        = 1'b1;
        end
      end
      PH_EXTLEN: begin
        length_acc_next   = la_acc;
        length_over_next  = la_over;
        header_count_next = hc_dec;
        after_len         = (hc_dec == 4'd0);
      end
      PH_MASK: begin
        mask_key_next     = {mask_key[23:0], ibuf_byte};
        header_count_next = hc_dec;
        start_body        = (hc_dec == 4'd0);
      end
      PH_BODY: begin
        bytes_left_next = bl_dec;
        if (bl_dec == '0) begin
          phase_next = PH_HDR0;
        end
        if (pend_error) begin
          if (bl_dec == '0) begin
            emit           = 1'b1;
            res.kind       = KIND_END;
            res.end_reason = pend_reason;
            phase_next     = PH_HALT;
          end
        end else begin
          mask_index_next = mask_index + 2'd1;
          if (held_opcode != OP_PONG) begin
            emit             = 1'b1;
            res.kind         = KIND_DATA;
            res.payload_byte = mflag ? (ibuf_byte ^ key_byte) : ibuf_byte;
            res.last_byte    = (bl_dec == '0);
          end
        end
      end
      PH_HALT: begin
        phase_next = PH_HALT;
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase

    // length complete: fixed limit first, then mask key or straight to body
    if (after_len) begin
      if (over_fixed) begin
        emit           = 1'b1;
        res.kind       = KIND_END;
        res.end_reason = RSN_OVERSIZE;
        phase_next     = PH_HALT;
      end else if (mflag) begin
        header_count_next = KEY_BYTES;
        phase_next        = PH_MASK;
      end else begin
        start_body = 1'b1;
      end
    end

    // header complete
    if (start_body) begin
      bytes_left_next  = la_acc;
      mask_index_next  = 2'd0;
      pend_error_next  = chk_error;
      pend_reason_next = chk_reason;
      if (la_acc != '0) begin
        phase_next = PH_BODY;
      end else if (chk_error) begin
        emit           = 1'b1;
        res.kind       = KIND_END;
        res.end_reason = chk_reason;
        phase_next     = PH_HALT;
      end else begin
        phase_next = PH_HDR0;
        if (held_opcode != OP_PONG) begin
          emit     = 1'b1;
          res.kind = KIND_EMPTY;
        end
      end
    end
  end

  assign res_valid = advance & emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      header_count <= '0;
      held_opcode  <= '0;
      fin_flag     <= 1'b1;
      mask_flag    <= 1'b0;
      bytes_left   <= '0;
      mask_index   <= '0;
      pend_reason  <= '0;
      pend_error   <= 1'b0;
      length_over  <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      held_opcode  <= held_opcode_next;
      fin_flag     <= fin_flag_next;
      mask_flag    <= mask_flag_next;
      bytes_left   <= bytes_left_next;
      mask_index   <= mask_index_next;
      pend_reason  <= pend_reason_next;
      pend_error   <= pend_error_next;
      length_over  <= length_over_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mask_key   <= mask_key_next;
      length_acc <= length_acc_next;
    end
  end

  // once ended, the stream stays ended until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("deframer left halt without reset");

  a_end_halts: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_END |=> phase == PH_HALT)
    else $error("stream end result without halt");

  a_body_nonempty: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> bytes_left != '0)
    else $error("in body with no bytes left");

  a_hdr_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EXTLEN || phase == PH_MASK) |-> header_count != 4'd0)
    else $error("header byte count ran out");

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_ready)
    else $error("result produced with no room in output register");

endmodule

`default_nettype wire

// ----- rtl/wsd_out_reg.sv -----
// Output register for deframer results, drives the master stream side.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_out_reg
  import wsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        res_valid,
  input  wire result_t     res,
  output logic             out_ready,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  output logic [1:0]       m_axis_tuser
);

  result_t held;

  assign out_ready = ~m_axis_tvalid | m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && res_valid) begin
      held <= res;
    end
  end

  assign m_axis_tdata = {2'b00, held.end_reason, held.frame_opcode, held.payload_byte};
  assign m_axis_tlast = held.last_byte;
  assign m_axis_tuser = held.kind;

endmodule

`default_nettype wire

// ----- rtl/websocket_frame_deframer_unit.sv -----
// WebSocket receive-side frame deframer, top level.
// Depends on wsd_pkg, wsd_cfg_regs, wsd_parser, wsd_out_reg.
`timescale 1ns / 1ps
`default_nettype none

// Takes the received WebSocket byte stream one byte per item on the slave
// stream side and parses each frame header (FIN, opcode, mask bit, 7/16/64-bit
// length, 4-byte mask key). Payload bytes leave unmasked, one per item, with
// the frame opcode in tdata and tlast on the final byte of the frame; an empty
// frame gives one item of kind "empty". Pong frames are swallowed. A close
// frame, an unfinished (FIN clear) frame or one longer than max_payload is
// reported with a stream-end item when its last byte arrives, its payload
// suppressed; a length above MAX_FRAME_LEN ends the stream as soon as the
// length is known. After a stream-end item the block accepts and discards
// bytes until reset. Throughput is one byte per cycle while the master side
// keeps taking results: each byte passes an input register, one level of
// parse/unmask logic and the output register before its result reaches the
// master side. The input register only moves on when the output register has
// room, so once both are full a cycle without m_axis_tready also holds off
// the slave side in that same cycle (s_axis_tready follows m_axis_tready
// combinationally). max_payload is at register 0 (byte address 0) of the
// APB port and should only be written while no frame is in progress.

module websocket_frame_deframer_unit
  import wsd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = 1048576
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // slave stream: received bytes
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] byte_in
  // master stream: results
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [15:0]                m_axis_tdata,   // [7:0] payload_byte, [11:8] frame_opcode,
                                                     // [13:12] end_reason, [15:14] zero
  output logic                       m_axis_tlast,   // last_byte
  output logic [1:0]                 m_axis_tuser,   // [1:0] kind
  // APB configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  logic [MAX_PAYLOAD_W-1:0] max_payload;
  logic                     out_ready;
  logic                     res_valid;
  result_t                  res;

  wsd_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  wsd_parser #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_byte     (s_axis_tdata),
    .max_payload (max_payload),
    .out_ready   (out_ready),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsd_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res           (res),
    .out_ready     (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- tb/wsd_result_checker.sv -----
// Watches the byte, result and APB channels of the frame deframer, predicts
// every result item and compares it with what leaves the block.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_result_checker
  import wsd_pkg::*;
#(
  parameter int unsigned FRAME_LIMIT = 1048576
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [15:0]           m_axis_tdata,
  input  wire logic                  m_axis_tlast,
  input  wire logic [1:0]            m_axis_tuser,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  input  wire logic [31:0]           prdata,
  input  wire logic                  pready,
  output int                         fail_count,
  output int                         outstanding
);

  localparam logic [1:0] NO_REASON = 2'd0;
  localparam int         REPORT_MAX = 10;

  // Parser copy
  phase_t                   stage;
  logic [3:0]               hdr_left;
  logic [3:0]               op_reg;
  logic                     fin_bit;
  logic                     masked;
  logic [31:0]              key_word;
  logic [63:0]              len_word;
  logic [20:0]              remaining;
  logic [1:0]               key_pos;
  logic [1:0]               err_reason;
  logic                     err_flag;
  logic [MAX_PAYLOAD_W-1:0] payload_cap;

  result_t                  expected_results[$];
  result_t                  seen;
  result_t                  want;
  int                       errs;

  task automatic post(input logic [1:0] kind, input logic [7:0] data, input logic last,
                      input logic [1:0] reason);
    result_t r;
    r.kind         = kind;
    r.payload_byte = data;
    r.frame_opcode = op_reg;
    r.last_byte    = last;
    r.end_reason   = reason;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic finish_stream(input logic [1:0] reason);
    stage = PH_HALT;
    post(KIND_END, 8'h00, 1'b0, reason);
  endtask

  // Header complete: decide the frame's fate with the register as it is now
  task automatic open_body();
    remaining  = len_word[20:0];
    key_pos    = '0;
    err_flag   = 1'b1;
    err_reason = NO_REASON;
    if (op_reg == OP_CLOSE) err_reason = RSN_CLOSE;
    else if (!fin_bit) err_reason = RSN_FRAG;
    else if (len_word > 64'(payload_cap)) err_reason = RSN_OVERSIZE;
    else err_flag = 1'b0;
    if (remaining != '0) begin
      stage = PH_BODY;
    end else begin
      stage = PH_HDR0;
      if (err_flag) finish_stream(err_reason);
      else if (op_reg != OP_PONG) post(KIND_EMPTY, 8'h00, 1'b0, NO_REASON);
    end
  endtask

  task automatic length_done();
    if (len_word > 64'(FRAME_LIMIT)) begin
      finish_stream(RSN_OVERSIZE);
    end else if (masked) begin
      key_word = '0;
      hdr_left = KEY_BYTES;
      stage    = PH_MASK;
    end else begin
      open_body();
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [6:0] code;
    logic [7:0] plain;
    case (stage)
      PH_HDR0: begin
        fin_bit = b[7];
        op_reg  = b[3:0];
        stage   = PH_HDR1;
      end
      PH_HDR1: begin
        masked   = b[7];
        code     = b[6:0];
        len_word = '0;
        if (code == LEN_CODE_16) begin
          hdr_left = EXT16_BYTES;
          stage    = PH_EXTLEN;
        end else if (code == LEN_CODE_64) begin
          hdr_left = EXT64_BYTES;
          stage    = PH_EXTLEN;
        end else begin
          len_word = 64'(code);
          length_done();
        end
      end
      PH_EXTLEN: begin
        len_word = {len_word[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == '0) length_done();
      end
      PH_MASK: begin
        key_word = {key_word[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == '0) open_body();
      end
      PH_BODY: begin
        remaining = remaining - 21'd1;
        if (remaining == '0) stage = PH_HDR0;
        if (err_flag) begin
          if (remaining == '0) finish_stream(err_reason);
        end else begin
          plain   = b ^ (masked ? key_word[8*(3-key_pos) +: 8] : 8'h00);
          key_pos = key_pos + 2'd1;
          if (op_reg != OP_PONG) post(KIND_DATA, plain, remaining == '0, NO_REASON);
        end
      end
      default: ;  // halted: byte dropped
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stage       = PH_HDR0;
      hdr_left    = '0;
      op_reg      = '0;
      fin_bit     = 1'b1;
      masked      = 1'b0;
      key_word    = '0;
      len_word    = '0;
      remaining   = '0;
      key_pos     = '0;
      err_reason  = NO_REASON;
      err_flag    = 1'b0;
      payload_cap = MAX_PAYLOAD_RST;
      expected_results.delete();
      errs        = 0;
    end else begin
      if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_MAX_PAYLOAD) begin
        if (pwrite) begin
          payload_cap = pwdata[MAX_PAYLOAD_W-1:0];
        end else if (prdata !== 32'(payload_cap)) begin
          errs++;
          if (errs <= REPORT_MAX)
            $display("max_payload read: expected %0d, got %0d", payload_cap, prdata);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.kind         = m_axis_tuser;
        seen.payload_byte = m_axis_tdata[7:0];
        seen.frame_opcode = m_axis_tdata[11:8];
        seen.end_reason   = m_axis_tdata[13:12];
        seen.last_byte    = m_axis_tlast;
        if (expected_results.size() == 0) begin
          errs++;
          if (errs <= REPORT_MAX)
            $display("unexpected result: kind %0d byte %02h op %h last %0d reason %0d",
                     seen.kind, seen.payload_byte, seen.frame_opcode, seen.last_byte,
                     seen.end_reason);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want || m_axis_tdata[15:14] !== 2'b00) begin
            errs++;
            if (errs <= REPORT_MAX) begin
              $display("result mismatch (exp/act): kind %0d/%0d byte %02h/%02h op %h/%h",
                       want.kind, seen.kind, want.payload_byte, seen.payload_byte,
                       want.frame_opcode, seen.frame_opcode);
              $display("  last %0d/%0d reason %0d/%0d pad %b",
                       want.last_byte, seen.last_byte, want.end_reason, seen.end_reason,
                       m_axis_tdata[15:14]);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata);
    end
    fail_count  <= errs;
    outstanding <= expected_results.size();
  end

endmodule

`default_nettype wire

// ----- tb/tb_websocket_frame_deframer_unit.sv -----
// Top of the frame deframer testbench: clock, reset, APB setup, byte stimulus
// and the verdict. Depends on wsd_pkg, wsd_result_checker and the block.
`timescale 1ns / 1ps
`default_nettype none

module tb_websocket_frame_deframer_unit;
  import wsd_pkg::*;

  localparam int unsigned FRAME_LIMIT   = 1048576;
  localparam int          CYCLE_LIMIT   = 400000;  // watchdog, well above a slow run
  localparam int          HOLD_CYCLES   = 300;     // one long receiver stall
  localparam int          SETTLE_CYCLES = 12;      // idle time after the last predicted result is out

  // Opcodes without special handling in the block
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_PING   = 4'h9;

  // Length encodings on the wire
  localparam int ENC_7  = 0;
  localparam int ENC_16 = 1;
  localparam int ENC_64 = 2;

  localparam logic [APB_ADDR_W-1:0] ADDR_MAX_PAYLOAD = {REG_MAX_PAYLOAD, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE       = 3'b100;  // no register here

  // How the stream is ended; the block halts for good, so only one per run
  typedef enum int {END_BY_CLOSE, END_BY_FRAG, END_BY_SIZE, END_BY_LIMIT} end_case_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;    // [7:0] byte_in
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [15:0]           m_axis_tdata;    // [7:0] payload_byte, [11:8] frame_opcode,
                                          // [13:12] end_reason, [15:14] zero
  logic                  m_axis_tlast;    // last_byte
  logic [1:0]            m_axis_tuser;    // [1:0] kind
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int                    fail_count;
  int                    outstanding;

  logic [7:0]            frame_bytes[$];  // wire bytes waiting to be sent
  bit                    calm;            // no idling on either side
  bit                    hold_req;        // ask the receiver for its long stall
  int                    gap_odds;        // sender idle odds in eighths, per phase

  websocket_frame_deframer_unit #(
    .MAX_FRAME_LEN (FRAME_LIMIT)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  wsd_result_checker #(
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends here
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Receiver side: random ready bursts, one long stall on request, none when calm.
  // Each branch makes one assignment and then waits at least one edge.
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // One byte item; optional idle burst ahead of it. Returns at the accepting edge.
  task automatic push_byte(input logic [7:0] b);
    if (!calm && gap_odds != 0 && $urandom_range(1, 8) <= gap_odds) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_frames();
    while (frame_bytes.size() != 0) push_byte(frame_bytes.pop_front());
  endtask

  // Sender stops and waits until every predicted result is out, then lets the
  // pipe run empty (pong frames leave nothing to wait for).
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup, access, then idle with psel low so back-to-back calls never collide
  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // New limit, then a readback the checker compares
  task automatic set_payload_cap(input logic [31:0] value);
    apb_access(1'b1, ADDR_MAX_PAYLOAD, value);
    apb_access(1'b0, ADDR_MAX_PAYLOAD, 32'h0);
  endtask

  // Anything but close; mostly the common opcodes
  function automatic logic [3:0] pick_opcode();
    logic [3:0] op;
    case ($urandom_range(0, 5))
      0: op = OP_CONT;
      1: op = OP_TEXT;
      2: op = OP_BINARY;
      3: op = OP_PING;
      4: op = OP_PONG;
      default: begin
        op = 4'($urandom_range(0, 15));
        if (op == OP_CLOSE) op = OP_BINARY;
      end
    endcase
    return op;
  endfunction

  // Appends one wire byte to the send queue
  task automatic add_byte(input logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endtask

  // Header (random reserved bits), optional key, payload when the length is sane
  task automatic queue_frame(input logic [3:0] op, input logic fin, input logic mask_on,
                             input logic [63:0] len, input int enc);
    logic [31:0] key;
    logic [2:0]  rsv;
    key = $urandom;
    rsv = 3'($urandom_range(0, 7));
    add_byte({fin, rsv, op});
    case (enc)
      ENC_7:
        add_byte({mask_on, len[6:0]});
      ENC_16: begin
        add_byte({mask_on, LEN_CODE_16});
        add_byte(len[15:8]);
        add_byte(len[7:0]);
      end
      default: begin
        add_byte({mask_on, LEN_CODE_64});
        for (int i = 7; i >= 0; i--) add_byte(len[8*i +: 8]);
      end
    endcase
    if (mask_on)
      for (int i = 3; i >= 0; i--) add_byte(key[8*i +: 8]);
    if (len <= 64'(FRAME_LIMIT))
      for (int n = 0; n < int'(len); n++) add_byte(8'($urandom_range(0, 255)));
  endtask

  // Well-formed frames within the current limit until the byte budget is spent
  task automatic random_traffic(input int budget, input int unsigned cap);
    int          sent;
    int          pick;
    int          enc;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) len = $urandom_range(0, 12);
      else if (pick < 88) len = $urandom_range(13, 125);
      else if (pick < 95) len = $urandom_range(126, 300);
      else len = (cap <= 300) ? cap : 300;  // at the limit, or 300 when the limit is higher
      if (len > cap) len = cap;
      if (len <= 125) begin
        pick = $urandom_range(0, 9);
        enc  = (pick < 7) ? ENC_7 : (pick < 9) ? ENC_16 : ENC_64;
      end else begin
        enc = $urandom_range(0, 1) ? ENC_16 : ENC_64;
      end
      queue_frame(pick_opcode(), 1'b1, 1'($urandom_range(0, 1)), 64'(len), enc);
      sent += frame_bytes.size();
      send_frames();
    end
  endtask

  initial begin
    end_case_t         end_pick;
    int unsigned       cap;
    logic [63:0]       huge;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= 32'h0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    gap_odds      = 2;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset value of the limit, then an explicit write of the same value
    apb_access(1'b0, ADDR_MAX_PAYLOAD, 32'h0);
    set_payload_cap(32'd4096);

    // Directed frames: empty, masked, ping, pong with and without payload,
    // reserved bits with an unknown opcode over a 16-bit length, 64-bit zero length
    queue_frame(OP_TEXT,   1'b1, 1'b0, 64'd0, ENC_7);
    queue_frame(OP_BINARY, 1'b1, 1'b1, 64'd1, ENC_7);
    queue_frame(OP_PING,   1'b1, 1'b0, 64'd2, ENC_7);
    queue_frame(OP_PONG,   1'b1, 1'b0, 64'd1, ENC_7);
    queue_frame(OP_PONG,   1'b1, 1'b1, 64'd0, ENC_7);
    queue_frame(4'hF,      1'b1, 1'b0, 64'd1, ENC_16);
    queue_frame(OP_CONT,   1'b1, 1'b0, 64'd0, ENC_64);
    frame_bytes[0] = 8'h81;   // byte_in low and high extremes on the wire
    add_byte(8'h82);
    add_byte(8'h02);
    add_byte(8'h00);
    add_byte(8'hFF);
    send_frames();
    settle();

    // Zero limit: only empty frames pass; a stray write to an unused address
    set_payload_cap(32'd0);
    apb_access(1'b1, ADDR_SPARE, $urandom);
    apb_access(1'b0, ADDR_MAX_PAYLOAD, 32'h0);
    gap_odds = $urandom_range(0, 3);
    random_traffic(150, 0);
    settle();

    // Top of the range; a long frame keeps the sender busy through the long stall
    set_payload_cap(32'd1048576);
    gap_odds = 1;
    hold_req = 1'b1;
    queue_frame(OP_TEXT, 1'b1, 1'b1, 64'd200, ENC_16);
    send_frames();
    random_traffic(250, 1048576);
    settle();

    // Mid-range limits; one write carries junk above the register width
    cap = $urandom_range(1, 300);
    set_payload_cap(cap);
    gap_odds = $urandom_range(0, 3);
    random_traffic(230, cap);
    settle();

    cap = $urandom_range(126, 1000);
    set_payload_cap({11'($urandom_range(1, 2047)), 21'(cap)});
    gap_odds = $urandom_range(0, 3);
    random_traffic(230, cap);
    settle();

    // Last part: no idling anywhere
    calm = 1'b1;
    cap  = $urandom_range(1, 60);
    set_payload_cap(cap);
    random_traffic(230, cap);
    settle();

    // The frame that ends the stream, then bytes the halted block must drop
    cap = $urandom_range(0, 40);
    set_payload_cap(cap);
    end_pick = end_case_t'($urandom_range(0, 3));
    case (end_pick)
      END_BY_CLOSE:
        queue_frame(OP_CLOSE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    64'($urandom_range(0, 8)), ENC_7);
      END_BY_FRAG:
        queue_frame(pick_opcode(), 1'b0, 1'($urandom_range(0, 1)),
                    64'($urandom_range(0, 8)), ENC_7);
      END_BY_SIZE:
        queue_frame(pick_opcode(), 1'b1, 1'($urandom_range(0, 1)),
                    64'(cap + $urandom_range(1, 8)), $urandom_range(0, 1) ? ENC_7 : ENC_16);
      default: begin
        huge = {$urandom, $urandom};
        if (huge <= 64'(FRAME_LIMIT) || $urandom_range(0, 1)) huge = 64'(FRAME_LIMIT) + 64'd1;
        queue_frame(pick_opcode(), 1'b1, 1'($urandom_range(0, 1)), huge, ENC_64);
      end
    endcase
    repeat (40) add_byte(8'($urandom_range(0, 255)));
    send_frames();
    settle();

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
